### design/ndrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndrd_pkg: shared types and constants
// Timestamp width, register map, reset values and the structs that pass
// between the configuration block, the detection core and the top level.
// ----------------------------------------------------------------------------
package ndrd_pkg;

  // Internal timestamp width; the now_us port stays 48 bits wide.
  localparam int unsigned TIME_WIDTH = 48;

  localparam int unsigned NOW_WIDTH  = 48;
  localparam int unsigned DUR_WIDTH  = 24;
  localparam int unsigned DUTY_WIDTH = 8;
  localparam int unsigned PWR_WIDTH  = 9;
  localparam int unsigned ADDR_WIDTH = 5;
  localparam int unsigned DATA_WIDTH = 32;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [DUR_WIDTH-1:0]  dur_t;
  typedef logic [DUTY_WIDTH-1:0] duty_t;

  typedef enum logic [2:0] {
    REG_ARRIVE_DELAY  = 3'd0,
    REG_EXIT_HOLDOFF  = 3'd1,
    REG_HOLD          = 3'd2,
    REG_SLOW_WINDOW   = 3'd3,
    REG_SLOW_POWER    = 3'd4,
    REG_OVERRIDE_EN   = 3'd5,
    REG_OVERRIDE_PWR  = 3'd6,
    REG_UNUSED        = 3'd7
  } reg_index_t;

  localparam dur_t  ARRIVE_DELAY_RST = 24'd150000;
  localparam dur_t  EXIT_HOLDOFF_RST = 24'd5000;
  localparam dur_t  HOLD_RST         = 24'd100000;
  localparam dur_t  SLOW_WINDOW_RST  = 24'd500000;
  localparam duty_t SLOW_POWER_RST   = 8'd89;
  localparam duty_t DUTY_FULL        = 8'd255;

  typedef struct packed {
    dur_t                        arrive_delay_us;
    dur_t                        exit_holdoff_us;
    dur_t                        hold_us;
    dur_t                        slow_window_us;
    duty_t                       slow_power;
    logic                        override_enable;
    logic signed [PWR_WIDTH-1:0] override_power;
  } cfg_t;

  typedef struct packed {
    logic  raw_detect;
    time_t now;
    logic  enabled;
    logic  amplify_event;
  } sample_t;

  typedef struct packed {
    duty_t fwd_duty;
    duty_t bwd_duty;
    logic  has_object;
    logic  score_pulse;
    logic  laser_on;
  } result_t;

endpackage
`default_nettype wire

### design/ndrd_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndrd_cfg_regs: configuration registers
// APB-style register file holding the timing windows and drive settings.
// ----------------------------------------------------------------------------
module ndrd_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ndrd_pkg::ADDR_WIDTH-1:0]       paddr,
  input  logic [ndrd_pkg::DATA_WIDTH-1:0]       pwdata,
  output logic [ndrd_pkg::DATA_WIDTH-1:0]       prdata,
  output logic                                  pready,
  output ndrd_pkg::cfg_t                        cfg
);

  ndrd_pkg::reg_index_t idx;
  logic                 wr_en;

  assign idx    = ndrd_pkg::reg_index_t'(paddr[ndrd_pkg::ADDR_WIDTH-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arrive_delay_us <= ndrd_pkg::ARRIVE_DELAY_RST;
      cfg.exit_holdoff_us <= ndrd_pkg::EXIT_HOLDOFF_RST;
      cfg.hold_us         <= ndrd_pkg::HOLD_RST;
      cfg.slow_window_us  <= ndrd_pkg::SLOW_WINDOW_RST;
      cfg.slow_power      <= ndrd_pkg::SLOW_POWER_RST;
      cfg.override_enable <= 1'b0;
      cfg.override_power  <= '0;
    end else if (wr_en) begin
      case (idx)
        ndrd_pkg::REG_ARRIVE_DELAY: cfg.arrive_delay_us <= pwdata[ndrd_pkg::DUR_WIDTH-1:0];
        ndrd_pkg::REG_EXIT_HOLDOFF: cfg.exit_holdoff_us <= pwdata[ndrd_pkg::DUR_WIDTH-1:0];
        ndrd_pkg::REG_HOLD:         cfg.hold_us         <= pwdata[ndrd_pkg::DUR_WIDTH-1:0];
        ndrd_pkg::REG_SLOW_WINDOW:  cfg.slow_window_us  <= pwdata[ndrd_pkg::DUR_WIDTH-1:0];
        ndrd_pkg::REG_SLOW_POWER:   cfg.slow_power      <= pwdata[ndrd_pkg::DUTY_WIDTH-1:0];
        ndrd_pkg::REG_OVERRIDE_EN:  cfg.override_enable <= pwdata[0];
        ndrd_pkg::REG_OVERRIDE_PWR: cfg.override_power  <= pwdata[ndrd_pkg::PWR_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      ndrd_pkg::REG_ARRIVE_DELAY: prdata = ndrd_pkg::DATA_WIDTH'(cfg.arrive_delay_us);
      ndrd_pkg::REG_EXIT_HOLDOFF: prdata = ndrd_pkg::DATA_WIDTH'(cfg.exit_holdoff_us);
      ndrd_pkg::REG_HOLD:         prdata = ndrd_pkg::DATA_WIDTH'(cfg.hold_us);
      ndrd_pkg::REG_SLOW_WINDOW:  prdata = ndrd_pkg::DATA_WIDTH'(cfg.slow_window_us);
      ndrd_pkg::REG_SLOW_POWER:   prdata = ndrd_pkg::DATA_WIDTH'(cfg.slow_power);
      ndrd_pkg::REG_OVERRIDE_EN:  prdata = ndrd_pkg::DATA_WIDTH'(cfg.override_enable);
      ndrd_pkg::REG_OVERRIDE_PWR: prdata = ndrd_pkg::DATA_WIDTH'(unsigned'(cfg.override_power));
      default:                    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### design/ndrd_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndrd_core: presence qualifier and ramp drive selection
// Holds the detection state and, for each sample moved on to the result
// register, works out presence, the score pulse and the motor duties.
// ----------------------------------------------------------------------------
module ndrd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  ndrd_pkg::cfg_t    cfg,
  input  ndrd_pkg::sample_t smp,
  output ndrd_pkg::result_t res
);

  ndrd_pkg::time_t enter_time, enter_time_next;
  ndrd_pkg::time_t exit_time, exit_time_next;
  ndrd_pkg::time_t seen_time, seen_time_next;
  logic            enter_valid, exit_valid, exit_valid_next;
  logic            seen_valid, seen_valid_next;
  logic            had_object, amplified_flag, amplified_flag_next;

  ndrd_pkg::time_t d_enter, d_exit, d_seen;
  logic            amp, det_arrived, holdoff_hit, det, has, in_slow;
  logic            new_run, early;
  ndrd_pkg::duty_t base_duty;
  logic [ndrd_pkg::PWR_WIDTH-1:0] neg_pwr;

  always_comb begin
    amp = amplified_flag || smp.amplify_event;

    // A new raw run starts its timer at this sample, so its elapsed time is zero.
    new_run         = smp.raw_detect && !enter_valid;
    enter_time_next = new_run ? smp.now : enter_time;
    d_enter         = smp.now - enter_time;
    early           = new_run ? (cfg.arrive_delay_us != '0)
                              : (d_enter < ndrd_pkg::TIME_WIDTH'(cfg.arrive_delay_us));
    det_arrived     = smp.raw_detect && !early;

    // Detections inside the exit holdoff are dropped and push it further out.
    d_exit      = smp.now - exit_time;
    holdoff_hit = det_arrived && exit_valid
                  && (d_exit < ndrd_pkg::TIME_WIDTH'(cfg.exit_holdoff_us));
    det         = det_arrived && !holdoff_hit;

    // A detection in this sample restarts the hold time from zero.
    seen_time_next  = det ? smp.now : seen_time;
    seen_valid_next = seen_valid || det;
    d_seen          = smp.now - seen_time;
    has             = det ? (cfg.hold_us != '0)
                          : (seen_valid && (d_seen < ndrd_pkg::TIME_WIDTH'(cfg.hold_us)));

    exit_time_next  = exit_time;
    exit_valid_next = exit_valid;
    if (holdoff_hit || (had_object && !has)) begin
      exit_time_next = smp.now;
    end
    if (had_object && !has) begin
      exit_valid_next = 1'b1;
    end

    amplified_flag_next = amp && has;

    in_slow = smp.raw_detect
              && (new_run ? (cfg.slow_window_us != '0)
                          : (d_enter < ndrd_pkg::TIME_WIDTH'(cfg.slow_window_us)));
    if (!has) begin
      base_duty = ndrd_pkg::DUTY_FULL;
    end else if (amp) begin
      base_duty = ndrd_pkg::DUTY_FULL;
    end else if (in_slow) begin
      base_duty = cfg.slow_power;
    end else begin
      base_duty = '0;
    end

    neg_pwr = -unsigned'(cfg.override_power);

    res.has_object  = has;
    res.score_pulse = has && !had_object;
    res.laser_on    = smp.enabled;
    res.fwd_duty    = '0;
    res.bwd_duty    = '0;
    if (smp.enabled) begin
      if (cfg.override_enable) begin
        if (cfg.override_power > 0) begin
          res.fwd_duty = cfg.override_power[ndrd_pkg::DUTY_WIDTH-1:0];
        end else if (neg_pwr[ndrd_pkg::PWR_WIDTH-1] && (cfg.override_power != 0)) begin
          // The most negative override saturates the backward duty.
          res.bwd_duty = ndrd_pkg::DUTY_FULL;
        end else begin
          res.bwd_duty = neg_pwr[ndrd_pkg::DUTY_WIDTH-1:0];
        end
      end else begin
        res.fwd_duty = base_duty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enter_time     <= '0;
      exit_time      <= '0;
      seen_time      <= '0;
      enter_valid    <= 1'b0;
      exit_valid     <= 1'b0;
      seen_valid     <= 1'b0;
      had_object     <= 1'b0;
      amplified_flag <= 1'b0;
    end else if (advance) begin
      enter_time     <= enter_time_next;
      exit_time      <= exit_time_next;
      seen_time      <= seen_time_next;
      enter_valid    <= smp.raw_detect;
      exit_valid     <= exit_valid_next;
      seen_valid     <= seen_valid_next;
      had_object     <= has;
      amplified_flag <= amplified_flag_next;
    end
  end

endmodule
`default_nettype wire

### design/note_detect_ramp_drive.sv
`default_nettype none
// ----------------------------------------------------------------------------
// note_detect_ramp_drive: object detection qualifier and ramp motor drive
// Qualifies a raw detector level against arrival, exit and hold times,
// flags new arrivals and drives the ramp motor as forward/backward duty.
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle while in_stall is low. A sample first
// lands in the input register, then the qualifier and drive logic evaluates
// it against the stored detection state and the outcome is captured in the
// result register. While a result is held by out_stall, one further sample
// is still taken into the input register; the stall reaches in_stall only
// once both registers are full. Configuration registers should be written
// only while no sample is in flight.
module note_detect_ramp_drive (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               raw_detect,
  input  logic [ndrd_pkg::NOW_WIDTH-1:0]     now_us,
  input  logic                               enabled,
  input  logic                               amplify_event,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ndrd_pkg::DUTY_WIDTH-1:0]    fwd_duty,
  output logic [ndrd_pkg::DUTY_WIDTH-1:0]    bwd_duty,
  output logic                               has_object,
  output logic                               score_pulse,
  output logic                               laser_on,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ndrd_pkg::ADDR_WIDTH-1:0]    paddr,
  input  logic [ndrd_pkg::DATA_WIDTH-1:0]    pwdata,
  output logic [ndrd_pkg::DATA_WIDTH-1:0]    prdata,
  output logic                               pready
);

  ndrd_pkg::cfg_t    cfg;
  ndrd_pkg::sample_t smp;
  ndrd_pkg::result_t res, res_q;
  logic              smp_valid, advance, in_take;
  logic [63:0]       now_ext;

  assign advance  = smp_valid && !(out_valid && out_stall);
  assign in_stall = smp_valid && !advance;
  assign in_take  = in_valid && !in_stall;
  assign now_ext  = 64'(now_us);

  ndrd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ndrd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .smp     (smp),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (in_take) begin
      smp_valid <= 1'b1;
    end else if (advance) begin
      smp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      smp.raw_detect    <= raw_detect;
      smp.now           <= now_ext[ndrd_pkg::TIME_WIDTH-1:0];
      smp.enabled       <= enabled;
      smp.amplify_event <= amplify_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign fwd_duty    = res_q.fwd_duty;
  assign bwd_duty    = res_q.bwd_duty;
  assign has_object  = res_q.has_object;
  assign score_pulse = res_q.score_pulse;
  assign laser_on    = res_q.laser_on;

`ifndef ASSERT_OFF
  a_pulse_has_object: assert property (@(posedge clk) disable iff (rst)
    out_valid && score_pulse |-> has_object)
    else $error("score pulse without presence");

  a_single_direction: assert property (@(posedge clk) disable iff (rst)
    out_valid && (fwd_duty != 0) |-> (bwd_duty == 0) && laser_on)
    else $error("forward duty with backward duty or while disabled");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("evaluated sample lost before the result register");
`endif

endmodule
`default_nettype wire

### bench/ndrd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ndrd_checker: result predictor and scoreboard for note_detect_ramp_drive
// Follows register writes on the configuration port, predicts one result for
// every accepted request on the sample channel and compares each accepted
// result, field by field, with the oldest prediction still pending.
// ----------------------------------------------------------------------------
module ndrd_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            raw_detect,
  input  logic [ndrd_pkg::NOW_WIDTH-1:0]  now_us,
  input  logic                            enabled,
  input  logic                            amplify_event,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [ndrd_pkg::DUTY_WIDTH-1:0] fwd_duty,
  input  logic [ndrd_pkg::DUTY_WIDTH-1:0] bwd_duty,
  input  logic                            has_object,
  input  logic                            score_pulse,
  input  logic                            laser_on,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [ndrd_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [ndrd_pkg::DATA_WIDTH-1:0] pwdata,
  output int                              outstanding,
  output int                              mismatches
);
  import ndrd_pkg::*;

  // Shadow copy of the configuration registers.
  dur_t                  arrive_us;
  dur_t                  holdoff_us;
  dur_t                  keep_us;
  dur_t                  window_us;
  duty_t                 slow_duty;
  logic                  ovr_on;
  logic signed [PWR_WIDTH-1:0] ovr_power;

  // Detection state of the predictor.
  time_t run_start;
  logic  run_start_ok;
  time_t leave_time;
  logic  leave_ok;
  time_t last_seen;
  logic  last_seen_ok;
  logic  was_present;
  logic  boost_pending;

  result_t expected_results[$];

  initial begin
    outstanding = 0;
    mismatches  = 0;
  end

  task automatic qualify_and_drive(input logic raw, input time_t now, input logic en,
                                   input logic amp, output result_t res);
    logic  det;
    logic  present;
    time_t elapsed;
    int    drive;
    int    mag;
    begin
      if (amp) boost_pending = 1'b1;
      if (!raw) run_start_ok = 1'b0;
      if (raw && !run_start_ok) begin
        run_start    = now;
        run_start_ok = 1'b1;
      end
      det = raw;
      elapsed = now - run_start;
      if (det && elapsed < time_t'(arrive_us)) det = 1'b0;
      elapsed = now - leave_time;
      // Ignored detections push the holdoff further out.
      if (det && leave_ok && elapsed < time_t'(holdoff_us)) begin
        det        = 1'b0;
        leave_time = now;
      end
      if (det) begin
        last_seen    = now;
        last_seen_ok = 1'b1;
      end
      elapsed = now - last_seen;
      present = last_seen_ok && (elapsed < time_t'(keep_us));
      res.score_pulse = !was_present && present;
      if (was_present && !present) begin
        leave_time = now;
        leave_ok   = 1'b1;
      end
      was_present = present;

      drive = en ? 255 : 0;
      if (present) drive = 0;
      elapsed = now - run_start;
      if (present && run_start_ok && elapsed < time_t'(window_us)) drive = int'(slow_duty);
      if (present && boost_pending) drive = 255;
      if (ovr_on) drive = int'(ovr_power);
      if (!en) drive = 0;

      if (drive > 0) begin
        res.fwd_duty = duty_t'(drive);
        res.bwd_duty = '0;
      end else begin
        mag = -drive;
        res.fwd_duty = '0;
        res.bwd_duty = (mag > 255) ? DUTY_FULL : duty_t'(mag);
      end
      boost_pending  = boost_pending && present;
      res.has_object = present;
      res.laser_on   = en;
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t predicted;
    result_t oldest;
    if (rst) begin
      arrive_us     = ARRIVE_DELAY_RST;
      holdoff_us    = EXIT_HOLDOFF_RST;
      keep_us       = HOLD_RST;
      window_us     = SLOW_WINDOW_RST;
      slow_duty     = SLOW_POWER_RST;
      ovr_on        = 1'b0;
      ovr_power     = '0;
      run_start     = '0;
      run_start_ok  = 1'b0;
      leave_time    = '0;
      leave_ok      = 1'b0;
      last_seen     = '0;
      last_seen_ok  = 1'b0;
      was_present   = 1'b0;
      boost_pending = 1'b0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[4:2]))
          REG_ARRIVE_DELAY: arrive_us  = pwdata[DUR_WIDTH-1:0];
          REG_EXIT_HOLDOFF: holdoff_us = pwdata[DUR_WIDTH-1:0];
          REG_HOLD:         keep_us    = pwdata[DUR_WIDTH-1:0];
          REG_SLOW_WINDOW:  window_us  = pwdata[DUR_WIDTH-1:0];
          REG_SLOW_POWER:   slow_duty  = pwdata[DUTY_WIDTH-1:0];
          REG_OVERRIDE_EN:  ovr_on     = pwdata[0];
          REG_OVERRIDE_PWR: ovr_power  = pwdata[PWR_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        qualify_and_drive(raw_detect, time_t'(now_us), enabled, amplify_event, predicted);
        expected_results.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing pending: fwd %0d bwd %0d obj %0d pulse %0d laser %0d",
                   $time, fwd_duty, bwd_duty, has_object, score_pulse, laser_on);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          compare_field("fwd_duty", oldest.fwd_duty, fwd_duty);
          compare_field("bwd_duty", oldest.bwd_duty, bwd_duty);
          compare_field("has_object", oldest.has_object, has_object);
          compare_field("score_pulse", oldest.score_pulse, score_pulse);
          compare_field("laser_on", oldest.laser_on, laser_on);
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for note_detect_ramp_drive
// Drives directed and random detector samples through several register
// settings, with random gaps and output stalls, and reports the outcome
// counted by the checker.
// ----------------------------------------------------------------------------
module testbench;
  import ndrd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic                  raw_detect    = 1'b0;
  logic [NOW_WIDTH-1:0]  now_us        = '0;
  logic                  enabled       = 1'b0;
  logic                  amplify_event = 1'b0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [DUTY_WIDTH-1:0] fwd_duty;
  logic [DUTY_WIDTH-1:0] bwd_duty;
  logic                  has_object;
  logic                  score_pulse;
  logic                  laser_on;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr         = '0;
  logic [DATA_WIDTH-1:0] pwdata        = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  int                    outstanding;
  int                    mismatches;
  int                    idle_cycles = 0;
  int                    stall_left  = 0;
  logic                  quiet       = 1'b0;
  logic [NOW_WIDTH-1:0]  stamp_us    = '0;

  always #1 clk = ~clk;

  note_detect_ramp_drive dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .raw_detect(raw_detect), .now_us(now_us), .enabled(enabled),
    .amplify_event(amplify_event),
    .out_valid(out_valid), .out_stall(out_stall),
    .fwd_duty(fwd_duty), .bwd_duty(bwd_duty), .has_object(has_object),
    .score_pulse(score_pulse), .laser_on(laser_on),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ndrd_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .raw_detect(raw_detect), .now_us(now_us), .enabled(enabled),
    .amplify_event(amplify_event),
    .out_valid(out_valid), .out_stall(out_stall),
    .fwd_duty(fwd_duty), .bwd_duty(bwd_duty), .has_object(has_object),
    .score_pulse(score_pulse), .laser_on(laser_on),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .outstanding(outstanding), .mismatches(mismatches)
  );

  // Mostly no pause, sometimes a short one, now and then a long one.
  function automatic int idle_length();
    if (quiet || $urandom_range(0, 99) >= 30) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    int len;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      len = idle_length();
      out_stall  <= (len > 0);
      stall_left = (len > 0) ? len - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic raw, input logic [NOW_WIDTH-1:0] now,
                             input logic en, input logic amp);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    raw_detect    <= raw;
    now_us        <= now;
    enabled       <= en;
    amplify_event <= amp;
    stamp_us = now;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [DATA_WIDTH-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Nothing may be in flight when registers change.
  task automatic settle();
    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input dur_t arrive, input dur_t holdoff, input dur_t keep,
                              input dur_t window, input duty_t slow, input logic ovr_on,
                              input logic [PWR_WIDTH-1:0] ovr_power);
    settle();
    write_reg(REG_ARRIVE_DELAY, DATA_WIDTH'(arrive));
    write_reg(REG_EXIT_HOLDOFF, DATA_WIDTH'(holdoff));
    write_reg(REG_HOLD, DATA_WIDTH'(keep));
    write_reg(REG_SLOW_WINDOW, DATA_WIDTH'(window));
    write_reg(REG_SLOW_POWER, DATA_WIDTH'(slow));
    write_reg(REG_OVERRIDE_EN, DATA_WIDTH'(ovr_on));
    write_reg(REG_OVERRIDE_PWR, DATA_WIDTH'(ovr_power));
  endtask

  // Runs of raw detection with timestamps that move forward by up to step_max,
  // mixed with scattered levels that step up to four times as far and the odd arbitrary jump of the timestamp.
  task automatic random_run(input int count, input int unsigned step_max);
    int          kind;
    int          run_left;
    logic        level;
    logic        raw;
    logic [63:0] wide;
    logic [NOW_WIDTH-1:0] next_us;
    run_left = 0;
    level    = 1'b0;
    repeat (count) begin
      if ($urandom_range(0, 99) == 0) quiet = !quiet;
      if (run_left == 0) begin
        level    = !level;
        run_left = $urandom_range(1, 12);
      end
      run_left--;
      kind = $urandom_range(0, 99);
      raw  = level;
      if (kind < 85) begin
        next_us = stamp_us + NOW_WIDTH'($urandom_range(0, step_max));
      end else if (kind < 95) begin
        raw     = 1'($urandom_range(0, 1));
        next_us = stamp_us + NOW_WIDTH'($urandom_range(0, 4 * step_max));
      end else begin
        raw     = 1'($urandom_range(0, 1));
        wide    = {$urandom, $urandom};
        next_us = wide[NOW_WIDTH-1:0];
      end
      send_sample(raw, next_us, $urandom_range(0, 9) != 0, $urandom_range(0, 19) == 0);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: arrival, slow window, amplify, disable and timestamp wrap.
    send_sample(1'b0, 48'd0, 1'b0, 1'b0);
    send_sample(1'b0, 48'd1000, 1'b1, 1'b0);
    send_sample(1'b1, 48'd10000, 1'b1, 1'b0);
    send_sample(1'b1, 48'd100000, 1'b1, 1'b0);
    send_sample(1'b1, 48'd170000, 1'b1, 1'b0);
    send_sample(1'b1, 48'd600000, 1'b1, 1'b0);
    send_sample(1'b1, 48'd610000, 1'b1, 1'b1);
    send_sample(1'b0, 48'd650000, 1'b1, 1'b0);
    send_sample(1'b0, 48'd650001, 1'b0, 1'b0);
    send_sample(1'b0, 48'd800000, 1'b1, 1'b0);
    send_sample(1'b1, 48'd801000, 1'b1, 1'b0);
    send_sample(1'b1, 48'd960000, 1'b1, 1'b0);
    send_sample(1'b1, 48'hFFFF_FFFF_FFF0, 1'b1, 1'b0);
    send_sample(1'b1, 48'h0000_0000_0010, 1'b1, 1'b0);
    send_sample(1'b0, 48'h0000_0002_0000, 1'b1, 1'b0);
    random_run(200, 60000);

    // Short times: exit holdoff that re-arms on ignored detections.
    apply_config(24'd10, 24'd100, 24'd30, 24'd50, 8'd200, 1'b0, 9'd0);
    send_sample(1'b1, stamp_us + 48'd5000, 1'b1, 1'b0);
    send_sample(1'b1, stamp_us + 48'd10, 1'b1, 1'b0);
    send_sample(1'b0, stamp_us + 48'd40, 1'b1, 1'b0);
    send_sample(1'b1, stamp_us + 48'd10, 1'b1, 1'b0);
    send_sample(1'b1, stamp_us + 48'd20, 1'b1, 1'b0);
    send_sample(1'b1, stamp_us + 48'd90, 1'b1, 1'b0);
    send_sample(1'b1, stamp_us + 48'd130, 1'b1, 1'b0);
    random_run(300, 40);

    // All times zero, full slow duty, back to back.
    quiet = 1'b1;
    apply_config(24'd0, 24'd0, 24'd0, 24'd0, 8'd255, 1'b0, 9'd0);
    random_run(150, 10);
    quiet = 1'b0;

    // All times at their largest, zero slow duty.
    apply_config(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 8'd0, 1'b0, 9'd0);
    random_run(150, 4000000);

    // Override drive: full forward, beyond full backward, full backward, zero, one.
    apply_config(24'd50, 24'd20, 24'd80, 24'd200, 8'd30, 1'b1, 9'h0FF);
    random_run(60, 60);
    apply_config(24'd50, 24'd20, 24'd80, 24'd200, 8'd30, 1'b1, 9'h100);
    random_run(60, 60);
    apply_config(24'd50, 24'd20, 24'd80, 24'd200, 8'd30, 1'b1, 9'h101);
    random_run(60, 60);
    apply_config(24'd50, 24'd20, 24'd80, 24'd200, 8'd30, 1'b1, 9'h000);
    random_run(40, 60);
    apply_config(24'd50, 24'd20, 24'd80, 24'd200, 8'd30, 1'b1, 9'h001);
    random_run(40, 60);

    // Random moderate settings.
    repeat (3) begin
      apply_config(dur_t'($urandom_range(0, 300)), dur_t'($urandom_range(0, 300)),
                   dur_t'($urandom_range(0, 400)), dur_t'($urandom_range(0, 800)),
                   duty_t'($urandom_range(0, 255)), 1'b0,
                   PWR_WIDTH'($urandom_range(0, 511)));
      random_run(100, 60);
    end

    settle();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### files.f
design/ndrd_pkg.sv
design/ndrd_cfg_regs.sv
design/ndrd_core.sv
design/note_detect_ramp_drive.sv
bench/ndrd_checker.sv
bench/testbench.sv
